// ----- design/trts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trts_pkg
// Shared types, widths and helpers for the torus reduction-tree setup block.
// ----------------------------------------------------------------------------
package trts_pkg;

    localparam int NUM_DIMS = 4;
    localparam int COORD_W  = 4;
    localparam int SIZE_W   = 5;
    localparam int WIRE_W   = 3;
    localparam int MASK_W   = 2 * NUM_DIMS;
    localparam int PROD2_W  = 2 * SIZE_W;
    localparam int NODES_W  = 4 * SIZE_W;
    localparam int LOG_W    = 5;
    localparam int RETRY_W  = 16;
    localparam int CMB_W    = 16;

    // Wire numbers with a fixed role: wire 1 is the positive wire of dimension 0
    localparam logic [WIRE_W-1:0] WIRE_DIM0_POS = 3'd1;
    localparam logic [MASK_W-1:0] MASK_DIM0_BOTH = 8'h03;
    localparam logic [MASK_W-1:0] MASK_DIM0_POS  = 8'h02;

    typedef struct packed {
        logic [COORD_W-1:0] master_coord_0;
        logic [COORD_W-1:0] master_coord_1;
        logic [COORD_W-1:0] master_coord_2;
        logic [COORD_W-1:0] master_coord_3;
        logic [COORD_W-1:0] node_coord_0;
        logic [COORD_W-1:0] node_coord_1;
        logic [COORD_W-1:0] node_coord_2;
        logic [COORD_W-1:0] node_coord_3;
        logic [SIZE_W-1:0]  dim_size_0;
        logic [SIZE_W-1:0]  dim_size_1;
        logic [SIZE_W-1:0]  dim_size_2;
        logic [SIZE_W-1:0]  dim_size_3;
    } in_item_t;

    typedef struct packed {
        logic               is_not_master;
        logic [CMB_W-1:0]   combine_word;
        logic [MASK_W-1:0]  broadcast_word;
        logic [WIRE_W-1:0]  send_wire_index;
        logic [WIRE_W-1:0]  recv_wire_index;
        logic [LOG_W-1:0]   overflow_bits;
        logic [RETRY_W-1:0] effective_retry_limit;
        logic               coord_error;
    } out_item_t;

    // Recentred position of the node per dimension, with the grid marks
    typedef struct packed {
        logic [NUM_DIMS-1:0][SIZE_W-1:0] here;
        logic [NUM_DIMS-1:0][SIZE_W-1:0] mid;
        logic [NUM_DIMS-1:0][SIZE_W-1:0] top;
    } geom_t;

    typedef struct packed {
        logic              remote;
        logic [MASK_W-1:0] cmb;
        logic [MASK_W-1:0] brd;
        logic [WIRE_W-1:0] send;
        logic [WIRE_W-1:0] recv;
    } route_t;

    // a mod s for a 4-bit a and s >= 1, by four restoring subtract steps
    function automatic logic [COORD_W-1:0] mod_small(
        input logic [COORD_W-1:0] a,
        input logic [SIZE_W-1:0]  s
    );
        logic [SIZE_W+COORD_W-1:0] r;
        logic [SIZE_W+COORD_W-1:0] dv;
        r = {{SIZE_W{1'b0}}, a};
        for (int k = COORD_W - 1; k >= 0; k--)
        begin
            dv = {{COORD_W{1'b0}}, s} << k;
            if (r >= dv)
            begin
                r = r - dv;
            end
        end
        return r[COORD_W-1:0];
    endfunction

endpackage

// ----- design/trts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trts_in_if / trts_out_if
// Valid/ready channels carrying setup queries and their results.
// ----------------------------------------------------------------------------
interface trts_in_if;
    logic               valid;
    logic               ready;
    trts_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface trts_out_if;
    logic                valid;
    logic                ready;
    trts_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- design/trts_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trts_scan
// Dimension scan, 3 down to 0: builds passthrough masks and send/recv wires.
// ----------------------------------------------------------------------------
module trts_scan (
    input  trts_pkg::geom_t  geom,
    output trts_pkg::route_t route
);

    always_comb
    begin
        logic done;
        logic [trts_pkg::MASK_W-1:0] lo;
        logic [trts_pkg::MASK_W-1:0] hi;
        done       = 1'b0;
        route.cmb  = '0;
        route.brd  = '0;
        route.send = trts_pkg::WIRE_DIM0_POS;
        route.recv = trts_pkg::WIRE_DIM0_POS;
        route.remote = 1'b0;
        for (int d = trts_pkg::NUM_DIMS - 1; d >= 0; d--)
        begin
            lo = trts_pkg::MASK_W'(1) << (2 * d);
            hi = trts_pkg::MASK_W'(1) << (2 * d + 1);
            if (!done)
            begin
                if (d == 0 && geom.here[0] == geom.mid[0])
                begin
                    // master: takes from the positive side only, feeds both
                    route.cmb = route.cmb | trts_pkg::MASK_DIM0_POS;
                    route.brd = route.brd | trts_pkg::MASK_DIM0_BOTH;
                    done = 1'b1;
                end
                else
                begin
                    if (geom.here[d] != '0)
                    begin
                        route.cmb = route.cmb | lo;
                        route.brd = route.brd | lo;
                    end
                    if (geom.here[d] != geom.top[d])
                    begin
                        route.cmb = route.cmb | hi;
                        route.brd = route.brd | hi;
                    end
                    if (geom.here[d] != geom.mid[d])
                    begin
                        route.remote = 1'b1;
                        route.send = (geom.here[d] > geom.mid[d]) ?
                                     trts_pkg::WIRE_W'(2 * d) :
                                     trts_pkg::WIRE_W'(2 * d + 1);
                        route.recv = route.send;
                        // leaf on the outermost dimension: nothing passes through
                        if (d == trts_pkg::NUM_DIMS - 1 &&
                            (geom.here[d] == '0 || geom.here[d] == geom.top[d]))
                        begin
                            route.cmb = '0;
                            route.brd = '0;
                        end
                        if (d == 0)
                        begin
                            route.send = trts_pkg::WIRE_DIM0_POS;
                            route.cmb  = route.cmb | trts_pkg::MASK_DIM0_BOTH;
                        end
                        done = 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ----- design/torus_reduction_tree_setup_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_reduction_tree_setup_top
// Reduction-tree setup for one node of a 4-D torus, four-stage pipeline.
// ----------------------------------------------------------------------------
// Pipeline: four register stages; the result is taken from the stage-4 register.
// Throughput: one query per cycle while the output keeps up; each stage is a register with its own
//   valid bit, so a stall on the output backs up without loss or repeat.
// Reset: rst_n clears all valid bits and sets the retry limit to 1; no
//   clearing pass, the block takes queries as soon as reset is released.
// ----------------------------------------------------------------------------
module torus_reduction_tree_setup_top #(
    parameter int DIM_SIZE_MAX = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    trts_in_if.sink                        in_ch,
    trts_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [trts_pkg::RETRY_W-1:0]   cfg_wdata
);

    // compare width covers both the raw size field and the saturation bound
    localparam int SAT_W = (trts_pkg::SIZE_W > $clog2(DIM_SIZE_MAX + 1)) ?
                           trts_pkg::SIZE_W : $clog2(DIM_SIZE_MAX + 1);

    typedef struct packed {
        logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::SIZE_W-1:0]  size;
        logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::SIZE_W-1:0]  top;
        logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::SIZE_W-1:0]  mid;
        logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::COORD_W-1:0] m;
        logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::COORD_W-1:0] c;
        logic                                                 err;
    } st1_t;

    typedef struct packed {
        trts_pkg::geom_t                geom;
        logic [trts_pkg::PROD2_W-1:0]   p01;
        logic [trts_pkg::PROD2_W-1:0]   p23;
        logic                           err;
    } st2_t;

    typedef struct packed {
        trts_pkg::route_t               route;
        logic [trts_pkg::NODES_W-1:0]   nodes;
        logic                           err;
    } st3_t;

    typedef struct packed {
        trts_pkg::route_t               route;
        logic [trts_pkg::LOG_W-1:0]     log2n;
        logic                           err;
    } st4_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    logic [trts_pkg::RETRY_W-1:0] retry_reg, retry_next;
    trts_pkg::route_t route;

    logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::SIZE_W-1:0]  raw_size;
    logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::COORD_W-1:0] raw_m;
    logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::COORD_W-1:0] raw_c;

    // ---------------- handshake ----------------
    assign rdy4 = !v4_reg || out_ch.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ch.ready = rdy1;

    assign v1_next = rdy1 ? in_ch.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    assign retry_next = (cfg_wdata == '0) ? trts_pkg::RETRY_W'(1) : cfg_wdata;

    // ---------------- stage 1: sizes, range check, reduce coordinates ----------------
    assign raw_size[0] = in_ch.payload.dim_size_0;
    assign raw_size[1] = in_ch.payload.dim_size_1;
    assign raw_size[2] = in_ch.payload.dim_size_2;
    assign raw_size[3] = in_ch.payload.dim_size_3;
    assign raw_m[0]    = in_ch.payload.master_coord_0;
    assign raw_m[1]    = in_ch.payload.master_coord_1;
    assign raw_m[2]    = in_ch.payload.master_coord_2;
    assign raw_m[3]    = in_ch.payload.master_coord_3;
    assign raw_c[0]    = in_ch.payload.node_coord_0;
    assign raw_c[1]    = in_ch.payload.node_coord_1;
    assign raw_c[2]    = in_ch.payload.node_coord_2;
    assign raw_c[3]    = in_ch.payload.node_coord_3;

    always_comb
    begin
        logic [trts_pkg::SIZE_W-1:0] s;
        st1_next.err = 1'b0;
        for (int d = 0; d < trts_pkg::NUM_DIMS; d++)
        begin
            s = raw_size[d];
            if (s == '0)
            begin
                s = trts_pkg::SIZE_W'(1);
                st1_next.err = 1'b1;
            end
            // saturate at the largest supported dimension
            if (SAT_W'(s) > SAT_W'(DIM_SIZE_MAX))
            begin
                s = trts_pkg::SIZE_W'(DIM_SIZE_MAX);
            end
            if (trts_pkg::SIZE_W'(raw_m[d]) >= s || trts_pkg::SIZE_W'(raw_c[d]) >= s)
            begin
                st1_next.err = 1'b1;
            end
            st1_next.size[d] = s;
            st1_next.top[d]  = s - trts_pkg::SIZE_W'(1);
            st1_next.mid[d]  = (s - trts_pkg::SIZE_W'(1)) >> 1;
            st1_next.m[d]    = trts_pkg::mod_small(raw_m[d], s);
            st1_next.c[d]    = trts_pkg::mod_small(raw_c[d], s);
        end
    end

    // ---------------- stage 2: recentre, pairwise size products ----------------
    always_comb
    begin
        logic [trts_pkg::SIZE_W+1:0] t;
        logic [trts_pkg::SIZE_W+1:0] sw;
        for (int d = 0; d < trts_pkg::NUM_DIMS; d++)
        begin
            sw = (trts_pkg::SIZE_W+2)'(st1_reg.size[d]);
            // c + mid + s - m stays below 3s: two compare-and-subtract steps
            t = (trts_pkg::SIZE_W+2)'(st1_reg.c[d]) + (trts_pkg::SIZE_W+2)'(st1_reg.mid[d])
                + sw - (trts_pkg::SIZE_W+2)'(st1_reg.m[d]);
            if (t >= sw)
            begin
                t = t - sw;
            end
            if (t >= sw)
            begin
                t = t - sw;
            end
            st2_next.geom.here[d] = t[trts_pkg::SIZE_W-1:0];
            st2_next.geom.mid[d]  = st1_reg.mid[d];
            st2_next.geom.top[d]  = st1_reg.top[d];
        end
        st2_next.p01 = trts_pkg::PROD2_W'(st1_reg.size[0]) * trts_pkg::PROD2_W'(st1_reg.size[1]);
        st2_next.p23 = trts_pkg::PROD2_W'(st1_reg.size[2]) * trts_pkg::PROD2_W'(st1_reg.size[3]);
        st2_next.err = st1_reg.err;
    end

    // ---------------- stage 3: dimension scan, node count ----------------
    trts_scan u_scan (
        .geom  (st2_reg.geom),
        .route (route)
    );

    always_comb
    begin
        st3_next.route = route;
        st3_next.nodes = trts_pkg::NODES_W'(st2_reg.p01) * trts_pkg::NODES_W'(st2_reg.p23);
        st3_next.err   = st2_reg.err;
    end

    // ---------------- stage 4: ceil log2 of node count, at least 1 ----------------
    always_comb
    begin
        logic [trts_pkg::NODES_W-1:0] x;
        x = st3_reg.nodes - trts_pkg::NODES_W'(1);
        st4_next.log2n = trts_pkg::LOG_W'(1);
        for (int i = 1; i < trts_pkg::NODES_W; i++)
        begin
            if (x[i])
            begin
                st4_next.log2n = trts_pkg::LOG_W'(i + 1);
            end
        end
        st4_next.route = st3_reg.route;
        st4_next.err   = st3_reg.err;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            retry_reg <= trts_pkg::RETRY_W'(1);
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            if (cfg_we)
            begin
                retry_reg <= retry_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            st1_reg <= st1_next;
        end
        if (rdy2)
        begin
            st2_reg <= st2_next;
        end
        if (rdy3)
        begin
            st3_reg <= st3_next;
        end
        if (rdy4)
        begin
            st4_reg <= st4_next;
        end
    end

    // ---------------- result ----------------
    assign out_ch.valid = v4_reg;
    assign out_ch.payload.is_not_master         = st4_reg.route.remote;
    assign out_ch.payload.combine_word          = {st4_reg.route.cmb, trts_pkg::MASK_W'(0)};
    assign out_ch.payload.broadcast_word        = st4_reg.route.brd;
    assign out_ch.payload.send_wire_index       = st4_reg.route.send;
    assign out_ch.payload.recv_wire_index       = st4_reg.route.recv;
    assign out_ch.payload.overflow_bits         = st4_reg.log2n;
    assign out_ch.payload.effective_retry_limit = retry_reg;
    assign out_ch.payload.coord_error           = st4_reg.err;

endmodule

// ----- design/trts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trts_checker
// Port-level checks on the result channel of the reduction-tree setup block.
// ----------------------------------------------------------------------------
module trts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input trts_pkg::out_item_t out_payload
);

    // Hold a stalled result unchanged until its transfer
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    a_cmb_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.combine_word[7:0] == 8'h00)
        else $error("combine word low byte not clear");

    a_master_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.is_not_master |->
            out_payload.send_wire_index == trts_pkg::WIRE_DIM0_POS &&
            out_payload.recv_wire_index == trts_pkg::WIRE_DIM0_POS &&
            out_payload.broadcast_word[1:0] == 2'b11 &&
            out_payload.combine_word[9] == 1'b1)
        else $error("master routing inconsistent");

    a_minimums: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.overflow_bits != '0 &&
            out_payload.effective_retry_limit != '0)
        else $error("log2 or retry limit below one");

endmodule

bind torus_reduction_tree_setup_top trts_checker u_trts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);

// ----- sim/tb_torus_reduction_tree_setup_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_torus_reduction_tree_setup_top
// Self-checking bench for the torus reduction-tree setup pipeline. Queries go
// in over the valid/ready input channel; each one is predicted at transfer and
// its expected route is queued, then compared field by field against the
// results in order. The retry limit is reprogrammed between phases while the
// pipe is empty; of three idle profiles, two stall both channels at random.
// ----------------------------------------------------------------------------
module tb_torus_reduction_tree_setup_top;

    localparam int DIM_SIZE_MAX = 16;
    localparam int LATENCY      = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int NUM_PHASES   = 6;

    typedef logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::COORD_W-1:0] coord_set_t;
    typedef logic [trts_pkg::NUM_DIMS-1:0][trts_pkg::SIZE_W-1:0]  size_set_t;

    class setup_scoreboard;
        trts_pkg::out_item_t expected_routes[$];
        logic [15:0]         retry_setting;
        int                  queries;
        int                  results;
        int                  failures;

        function new();
            retry_setting = 16'd1;
            queries       = 0;
            results       = 0;
            failures      = 0;
        endfunction

        function void set_retry(logic [trts_pkg::RETRY_W-1:0] value);
            retry_setting = value;
        endfunction

        function int pending();
            return expected_routes.size();
        endfunction

        function trts_pkg::out_item_t predict_route(trts_pkg::in_item_t q);
            int                  sz_raw[trts_pkg::NUM_DIMS];
            int                  mc[trts_pkg::NUM_DIMS];
            int                  nc[trts_pkg::NUM_DIMS];
            int                  top[trts_pkg::NUM_DIMS];
            int                  mid[trts_pkg::NUM_DIMS];
            int                  here[trts_pkg::NUM_DIMS];
            int                  s;
            int                  m;
            int                  c;
            int                  d;
            int                  bits;
            longint              nodes;
            longint              pw;
            logic [7:0]          cmb;
            logic [7:0]          brd;
            logic [7:0]          lo;
            logic [7:0]          hi;
            logic [2:0]          send;
            logic [2:0]          recv;
            logic                remote;
            logic                err;
            bit                  done;
            trts_pkg::out_item_t r;

            sz_raw = '{q.dim_size_0, q.dim_size_1, q.dim_size_2, q.dim_size_3};
            mc     = '{q.master_coord_0, q.master_coord_1, q.master_coord_2,
                       q.master_coord_3};
            nc     = '{q.node_coord_0, q.node_coord_1, q.node_coord_2, q.node_coord_3};
            err    = 1'b0;
            nodes  = 1;
            for (d = 0; d < trts_pkg::NUM_DIMS; d++)
            begin
                s = sz_raw[d];
                if (s == 0)
                begin
                    s   = 1;
                    err = 1'b1;
                end
                if (s > DIM_SIZE_MAX)
                begin
                    s = DIM_SIZE_MAX;
                end
                m = mc[d];
                c = nc[d];
                if (m >= s || c >= s)
                begin
                    err = 1'b1;
                end
                m       = m % s;
                c       = c % s;
                top[d]  = s - 1;
                mid[d]  = top[d] / 2;
                // recentre so the master lands mid-grid
                here[d] = (c + mid[d] + s - m) % s;
                nodes   = nodes * s;
            end

            cmb    = '0;
            brd    = '0;
            send   = trts_pkg::WIRE_DIM0_POS;
            recv   = trts_pkg::WIRE_DIM0_POS;
            remote = 1'b0;
            done   = 1'b0;
            for (d = trts_pkg::NUM_DIMS - 1; d >= 0 && !done; d--)
            begin
                lo = 8'(1) << (2 * d);
                hi = 8'(1) << (2 * d + 1);
                if (d == 0 && here[0] == mid[0])
                begin
                    // master itself: sources only from the positive dim-0 side
                    send   = trts_pkg::WIRE_DIM0_POS;
                    recv   = trts_pkg::WIRE_DIM0_POS;
                    remote = 1'b0;
                    cmb    = cmb | trts_pkg::MASK_DIM0_POS;
                    brd    = brd | trts_pkg::MASK_DIM0_BOTH;
                    done   = 1'b1;
                end
                else
                begin
                    if (here[d] != 0)
                    begin
                        brd = brd | lo;
                        cmb = cmb | lo;
                    end
                    if (here[d] != top[d])
                    begin
                        brd = brd | hi;
                        cmb = cmb | hi;
                    end
                    if (here[d] != mid[d])
                    begin
                        remote = 1'b1;
                        send = (here[d] > mid[d]) ? 3'(2 * d) : 3'(2 * d + 1);
                        recv = send;
                        // leaf on the outermost dimension: nothing passes through
                        if (d == trts_pkg::NUM_DIMS - 1 &&
                            (here[d] == 0 || here[d] == top[d]))
                        begin
                            cmb = '0;
                            brd = '0;
                        end
                        if (d == 0)
                        begin
                            send = trts_pkg::WIRE_DIM0_POS;
                            cmb  = cmb | trts_pkg::MASK_DIM0_BOTH;
                        end
                        done = 1'b1;
                    end
                end
            end

            bits = 1;
            pw   = 2;
            while (nodes > pw && bits < 31)
            begin
                bits++;
                pw = pw << 1;
            end

            r.is_not_master         = remote;
            r.combine_word          = {cmb, 8'h00};
            r.broadcast_word        = brd;
            r.send_wire_index       = send;
            r.recv_wire_index       = recv;
            r.overflow_bits         = trts_pkg::LOG_W'(bits);
            r.effective_retry_limit = (retry_setting > 16'd1) ? retry_setting : 16'd1;
            r.coord_error           = err;
            return r;
        endfunction

        function void note_query(trts_pkg::in_item_t q);
            expected_routes.push_back(predict_route(q));
            queries++;
        endfunction

        function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val)
            begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, exp_val, act_val);
                failures++;
            end
        endfunction

        function void check_result(trts_pkg::out_item_t got);
            trts_pkg::out_item_t want;
            if (expected_routes.size() == 0)
            begin
                $display("%0t: result with no query outstanding: 0x%0h", $time, got);
                failures++;
                return;
            end
            want = expected_routes.pop_front();
            results++;
            check_field("is_not_master", want.is_not_master, got.is_not_master);
            check_field("combine_word", want.combine_word, got.combine_word);
            check_field("broadcast_word", want.broadcast_word, got.broadcast_word);
            check_field("send_wire_index", want.send_wire_index, got.send_wire_index);
            check_field("recv_wire_index", want.recv_wire_index, got.recv_wire_index);
            check_field("overflow_bits", want.overflow_bits, got.overflow_bits);
            check_field("effective_retry_limit", want.effective_retry_limit,
                        got.effective_retry_limit);
            check_field("coord_error", want.coord_error, got.coord_error);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [trts_pkg::RETRY_W-1:0] cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    trts_in_if  in_ch();
    trts_out_if out_ch();

    setup_scoreboard route_book = new();

    torus_reduction_tree_setup_top #(
        .DIM_SIZE_MAX (DIM_SIZE_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Arrays are written dimension 3 first, so element d is dimension d
    function automatic trts_pkg::in_item_t pack_query(coord_set_t m, coord_set_t n,
                                                      size_set_t s);
        trts_pkg::in_item_t q;
        q.master_coord_0 = m[0];
        q.master_coord_1 = m[1];
        q.master_coord_2 = m[2];
        q.master_coord_3 = m[3];
        q.node_coord_0   = n[0];
        q.node_coord_1   = n[1];
        q.node_coord_2   = n[2];
        q.node_coord_3   = n[3];
        q.dim_size_0     = s[0];
        q.dim_size_1     = s[1];
        q.dim_size_2     = s[2];
        q.dim_size_3     = s[3];
        return q;
    endfunction

    // Mostly legal grids; dimensions above a random lead match the master so
    // the scan reaches the lower dimensions often
    function automatic trts_pkg::in_item_t random_query();
        coord_set_t m;
        coord_set_t n;
        size_set_t  s;
        int         lead;
        int         eff;
        int         pick;
        lead = int'($urandom_range(0, trts_pkg::NUM_DIMS)) - 1;
        for (int d = 0; d < trts_pkg::NUM_DIMS; d++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                s[d] = '0;
            else if (pick < 8)
                s[d] = trts_pkg::SIZE_W'($urandom_range(DIM_SIZE_MAX + 1, 31));
            else if (pick < 35)
                s[d] = trts_pkg::SIZE_W'($urandom_range(1, 4));
            else
                s[d] = trts_pkg::SIZE_W'($urandom_range(1, DIM_SIZE_MAX));
            eff = (s[d] == 0) ? 1 : ((s[d] > DIM_SIZE_MAX) ? DIM_SIZE_MAX : s[d]);
            m[d] = trts_pkg::COORD_W'($urandom_range(0, eff - 1));
            n[d] = (d > lead) ? m[d] : trts_pkg::COORD_W'($urandom_range(0, eff - 1));
            if ($urandom_range(0, 99) < 4)
                m[d] = trts_pkg::COORD_W'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 4)
                n[d] = trts_pkg::COORD_W'($urandom_range(0, 15));
        end
        return pack_query(m, n, s);
    endfunction

    task automatic send_query(trts_pkg::in_item_t q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= q;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        route_book.note_query(q);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (route_book.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_retry(logic [trts_pkg::RETRY_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        route_book.set_retry(value);
    endtask

    task automatic run_directed();
        send_query(pack_query('0, '0, {4{5'd1}}));
        send_query(pack_query({4{4'hF}}, {4{4'hF}}, {4{5'd16}}));
        send_query(pack_query('0, {4{4'hF}}, {4{5'd16}}));
        // leaf on dimension 3, low and high boundary
        send_query(pack_query('0, {4'd9, 4'd0, 4'd0, 4'd0}, {4{5'd16}}));
        send_query(pack_query('0, {4'd8, 4'd0, 4'd0, 4'd0}, {4{5'd16}}));
        // node differs from the master along one dimension only (0, then 2 and 1)
        send_query(pack_query({4{4'd5}}, {4'd5, 4'd5, 4'd5, 4'd4}, {4{5'd16}}));
        send_query(pack_query({4{4'd5}}, {4'd5, 4'd5, 4'd5, 4'd6}, {4{5'd16}}));
        send_query(pack_query('0, {4'd0, 4'd0, 4'd0, 4'd9}, {4{5'd16}}));
        send_query(pack_query('0, {4'd0, 4'd0, 4'd0, 4'd8}, {4{5'd16}}));
        send_query(pack_query({4{4'd3}}, {4'd3, 4'd4, 4'd3, 4'd3}, {4{5'd8}}));
        send_query(pack_query({4{4'd3}}, {4'd3, 4'd3, 4'd2, 4'd3}, {4{5'd8}}));
        // zero sizes
        send_query(pack_query('0, '0, {5'd4, 5'd4, 5'd4, 5'd0}));
        send_query(pack_query('0, '0, {5'd0, 5'd4, 5'd4, 5'd4}));
        send_query(pack_query('0, '0, {4{5'd0}}));
        // oversized sizes saturate
        send_query(pack_query({4'd1, 4'd2, 4'd3, 4'd4}, {4'd4, 4'd3, 4'd2, 4'd1},
                              {5'd31, 5'd17, 5'd16, 5'd31}));
        // coordinates out of range wrap modulo the size, then in-range grids
        send_query(pack_query('0, {4'd0, 4'd0, 4'd0, 4'd15}, {4{5'd4}}));
        send_query(pack_query({4'd15, 4'd0, 4'd0, 4'd0}, {4'd1, 4'd0, 4'd0, 4'd0},
                              {4{5'd2}}));
        send_query(pack_query('0, {4{4'd1}}, {4{5'd2}}));
        send_query(pack_query({4{4'd2}}, '0, {4{5'd3}}));
        send_query(pack_query('0, {4'd0, 4'd0, 4'd0, 4'd5}, {5'd1, 5'd1, 5'd1, 5'd16}));
        send_query(pack_query('0, {4'd5, 4'd0, 4'd0, 4'd0}, {5'd16, 5'd1, 5'd1, 5'd1}));
        send_query(pack_query({4{4'hA}}, {4{4'h5}}, {4{5'd16}}));
        send_query(pack_query({4{4'h5}}, {4{4'hA}}, {4{5'd16}}));
        send_query(pack_query({4{4'd7}}, {4{4'd7}}, {4{5'd16}}));
    endtask

    // Result side: check on transfer, then pick next cycle's ready
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                route_book.check_result(out_ch.payload);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [trts_pkg::RETRY_W-1:0] retry_plan[NUM_PHASES];
        int                           phase_items;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        send_idle_pct = 17;
        recv_idle_pct = 47;
        retry_plan    = '{16'd1, 16'd0, 16'hFFFF,
                          trts_pkg::RETRY_W'($urandom_range(2, 16'hFFFE)), 16'd2, 16'd1};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 17;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // the first phase runs on the reset value of the retry limit
            if (phase != 0)
            begin
                write_retry(retry_plan[phase]);
            end
            else
            begin
                run_directed();
            end
            phase_items = (phase == 0) ? 300 : 325;
            for (int i = 0; i < phase_items; i++)
            begin
                send_query(random_query());
                if ($urandom_range(0, 199) == 0)
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (5 * LATENCY) @(posedge clk);

        $display("Checked %0d of %0d setup queries, %0d field mismatches",
                 route_book.results, route_book.queries, route_book.failures);
        $display("Retry limits 0, 1, 2, 0x%0h, 0xffff under three stall profiles",
                 retry_plan[3]);
        if (route_book.failures == 0 && route_book.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/trts_pkg.sv
design/trts_if.sv
design/trts_scan.sv
design/torus_reduction_tree_setup_top.sv
design/trts_checker.sv
sim/tb_torus_reduction_tree_setup_top.sv
